// ===== src/lzd_pkg.sv =====
`default_nettype none
package lzd_pkg;

    // window geometry
    localparam int WINDOW_BYTES = 8192;
    localparam int WIN_AW       = $clog2(WINDOW_BYTES);
    localparam int POS_W        = WIN_AW + 1;

    // stream constants
    localparam logic [7:0] MAGIC_BYTE = 8'h66;
    localparam logic [7:0] NO_MATCH   = 8'd253;
    localparam logic [7:0] END_MARK   = 8'd254;
    localparam logic [7:0] LIT_EXT_MAX = 8'd240;
    localparam logic [7:0] MEXT_MAX   = 8'd236;
    localparam logic [3:0] NIBBLE_MAX = 4'd15;
    localparam logic [7:0] MIN_MATCH  = 8'd4;

    // result status codes
    localparam logic [2:0] ST_DATA       = 3'd0;
    localparam logic [2:0] ST_END        = 3'd1;
    localparam logic [2:0] ST_END_UNUSED = 3'd2;
    localparam logic [2:0] ST_BAD_MAGIC  = 3'd3;
    localparam logic [2:0] ST_LIT_OVR    = 3'd4;
    localparam logic [2:0] ST_MATCH_OVR  = 3'd5;
    localparam logic [2:0] ST_BAD_OFF    = 3'd6;
    localparam logic [2:0] ST_TRUNC      = 3'd7;

    // literal count source
    localparam logic [1:0] LS_NONE  = 2'd0;
    localparam logic [1:0] LS_TOKEN = 2'd1;
    localparam logic [1:0] LS_EXT   = 2'd2;

    // match length source
    localparam logic [1:0] MS_NONE   = 2'd0;
    localparam logic [1:0] MS_NIB_IN = 2'd1;
    localparam logic [1:0] MS_NIB_RG = 2'd2;
    localparam logic [1:0] MS_EXT    = 2'd3;

    // result kind
    localparam logic [1:0] OK_LIT    = 2'd0;
    localparam logic [1:0] OK_BEAT   = 2'd1;
    localparam logic [1:0] OK_STATUS = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte0;
        logic [7:0]  out_byte1;
        logic [7:0]  out_byte2;
        logic [7:0]  out_byte3;
        logic [2:0]  byte_count;
        logic        run_last;
        logic [2:0]  status;
        logic [13:0] total_length;
    } t_out_item;

    typedef struct packed {
        logic       clr_pos;
        logic       ld_mnib;
        logic [1:0] lit_sel;
        logic       dec_lit;
        logic [1:0] mlen_sel;
        logic       ld_offlo;
        logic       start_copy;
        logic       lit_wr;
        logic       trunc_add;
        logic       rd;
        logic       wr_copy;
        logic       out_ld;
        logic [1:0] out_kind;
        logic [2:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic magic;
        logic hi15;
        logic hi0;
        logic lo15;
        logic mnib15;
        logic ext_gt240;
        logic ext_nomatch;
        logic ext_end;
        logic ext_gt236;
        logic tok_lit_ovf;
        logic ext_lit_ovf;
        logic lit_one;
        logic m_ovf;
        logic bad_off;
        logic rem_one;
        logic beat_full;
    } t_flags;

endpackage
`default_nettype wire

// ===== src/lz_image_decompressor.sv =====
// Streaming decompressor for a byte-oriented LZ format: a magic byte, then chunks of
// token, optional literal extension, literals, optional match extension and a 16-bit
// absolute offset. Each accepted compressed byte gives at most one result, except the
// final offset byte of a match, which gives one result beat per four copied bytes.
// A non-match byte is taken while the output register is free; a match copies
// through the 8 KiB window RAM, each byte a registered read and then a write-back,
// and holds input until the copy is done, plus any output stall. Status results
// carry no bytes; after an error or end without the last-byte mark, input is
// discarded up to and including the next marked byte.
`default_nettype none
module lz_image_decompressor
    import lzd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out
);

    t_cmd   cmd;
    t_flags flags;

    // parse and copy sequencer
    lzd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_in.last_in),
        .i_flags    (flags),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // window, counters and output register
    lzd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_flags     (flags),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// ===== src/lzd_ram.sv =====
`default_nettype none
module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule
`default_nettype wire

// ===== src/lzd_ctrl.sv =====
`default_nettype none
module lzd_ctrl
    import lzd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    input  wire logic   i_last,
    input  wire t_flags i_flags,
    output logic        o_in_stall,
    output t_cmd        o_cmd
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_WR   = 2'd2;

    // stream parse phases
    localparam logic [2:0] P_MAGIC    = 3'd0;
    localparam logic [2:0] P_TOKEN    = 3'd1;
    localparam logic [2:0] P_LITEXT   = 3'd2;
    localparam logic [2:0] P_LITS     = 3'd3;
    localparam logic [2:0] P_MATCHEXT = 3'd4;
    localparam logic [2:0] P_OFFLO    = 3'd5;
    localparam logic [2:0] P_OFFHI    = 3'd6;

    logic [1:0] r_state, n_state;
    logic [2:0] r_phase, n_phase;
    logic       r_skip, n_skip;

    assign o_in_stall = !((r_state == S_IDLE) && i_flags.out_free);

    // parse and copy sequencing
    always_comb begin
        logic       fin;
        logic       emit_lit;
        logic       go_copy;
        logic [2:0] st;
        o_cmd    = '0;
        n_state  = r_state;
        n_phase  = r_phase;
        n_skip   = r_skip;
        fin      = 1'b0;
        emit_lit = 1'b0;
        go_copy  = 1'b0;
        st       = ST_DATA;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_flags.out_free) begin
                    if (r_skip) begin
                        if (i_last) begin
                            n_skip = 1'b0;
                        end
                    end else begin
                        case (r_phase)
                            P_MAGIC: begin
                                o_cmd.clr_pos = 1'b1;
                                if (!i_flags.magic) begin
                                    fin = 1'b1;
                                    st  = ST_BAD_MAGIC;
                                end else begin
                                    n_phase = P_TOKEN;
                                end
                            end
                            P_TOKEN: begin
                                o_cmd.ld_mnib = 1'b1;
                                if (i_flags.hi15) begin
                                    n_phase = P_LITEXT;
                                end else if (i_flags.tok_lit_ovf) begin
                                    fin = 1'b1;
                                    st  = ST_LIT_OVR;
                                end else begin
                                    o_cmd.lit_sel = LS_TOKEN;
                                    if (!i_flags.hi0) begin
                                        n_phase = P_LITS;
                                    end else if (i_flags.lo15) begin
                                        n_phase = P_MATCHEXT;
                                    end else begin
                                        o_cmd.mlen_sel = MS_NIB_IN;
                                        n_phase        = P_OFFLO;
                                    end
                                end
                            end
                            P_LITEXT: begin
                                if (i_flags.ext_gt240 || i_flags.ext_lit_ovf) begin
                                    fin = 1'b1;
                                    st  = ST_LIT_OVR;
                                end else begin
                                    o_cmd.lit_sel = LS_EXT;
                                    n_phase       = P_LITS;
                                end
                            end
                            P_LITS: begin
                                o_cmd.lit_wr  = 1'b1;
                                o_cmd.dec_lit = 1'b1;
                                emit_lit      = 1'b1;
                                if (i_flags.lit_one) begin
                                    if (i_flags.mnib15) begin
                                        n_phase = P_MATCHEXT;
                                    end else begin
                                        o_cmd.mlen_sel = MS_NIB_RG;
                                        n_phase        = P_OFFLO;
                                    end
                                end
                            end
                            P_MATCHEXT: begin
                                if (i_flags.ext_nomatch) begin
                                    n_phase = P_TOKEN;
                                end else if (i_flags.ext_end) begin
                                    fin = 1'b1;
                                    st  = i_last ? ST_END : ST_END_UNUSED;
                                end else if (i_flags.ext_gt236) begin
                                    fin = 1'b1;
                                    st  = ST_MATCH_OVR;
                                end else begin
                                    o_cmd.mlen_sel = MS_EXT;
                                    n_phase        = P_OFFLO;
                                end
                            end
                            P_OFFLO: begin
                                o_cmd.ld_offlo = 1'b1;
                                n_phase        = P_OFFHI;
                            end
                            default: begin
                                if (i_flags.m_ovf) begin
                                    fin = 1'b1;
                                    st  = ST_MATCH_OVR;
                                end else if (i_flags.bad_off) begin
                                    fin = 1'b1;
                                    st  = ST_BAD_OFF;
                                end else begin
                                    n_phase = P_TOKEN;
                                    if (i_last) begin
                                        o_cmd.trunc_add = 1'b1;
                                    end else begin
                                        go_copy = 1'b1;
                                    end
                                end
                            end
                        endcase
                        // one result per byte at most outside a copy
                        if (fin) begin
                            n_phase          = P_MAGIC;
                            n_skip           = !i_last;
                            o_cmd.out_ld     = 1'b1;
                            o_cmd.out_kind   = OK_STATUS;
                            o_cmd.out_status = st;
                        end else if (i_last) begin
                            n_phase          = P_MAGIC;
                            n_skip           = 1'b0;
                            o_cmd.out_ld     = 1'b1;
                            o_cmd.out_kind   = OK_STATUS;
                            o_cmd.out_status = ST_TRUNC;
                        end else if (emit_lit) begin
                            o_cmd.out_ld   = 1'b1;
                            o_cmd.out_kind = OK_LIT;
                        end
                        if (go_copy) begin
                            o_cmd.start_copy = 1'b1;
                            n_state          = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WR;
            end
            S_WR: begin
                if ((!i_flags.beat_full && !i_flags.rem_one) || i_flags.out_free) begin
                    o_cmd.wr_copy = 1'b1;
                    if (i_flags.beat_full || i_flags.rem_one) begin
                        o_cmd.out_ld   = 1'b1;
                        o_cmd.out_kind = OK_BEAT;
                    end
                    n_state = i_flags.rem_one ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= P_MAGIC;
            r_skip  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_skip  <= n_skip;
        end
    end

endmodule
`default_nettype wire

// ===== src/lzd_dp.sv =====
`default_nettype none
module lzd_dp
    import lzd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_in,
    input  wire t_cmd      i_cmd,
    input  wire logic      i_out_stall,
    output t_flags         o_flags,
    output logic           o_out_valid,
    output t_out_item      o_out
);

    logic [7:0]       r_lit;
    logic [3:0]       r_mnib;
    logic [7:0]       r_mlen;
    logic [7:0]       r_offlo;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [WIN_AW-1:0] r_src;
    logic [7:0]       r_rem;
    logic [7:0]       r_beat [3];
    logic [1:0]       r_bcnt;
    logic             r_ov;
    t_out_item        r_out, n_out;
    logic [7:0]       b;
    logic [15:0]      off;
    logic [7:0]       q;
    logic             emit_beat;

    assign b   = i_in.in_byte;
    assign off = {b, r_offlo};

    // decode and range checks
    always_comb begin
        o_flags.out_free    = !r_ov || !i_out_stall;
        o_flags.magic       = (b == MAGIC_BYTE);
        o_flags.hi15        = (b[7:4] == NIBBLE_MAX);
        o_flags.hi0         = (b[7:4] == 4'd0);
        o_flags.lo15        = (b[3:0] == NIBBLE_MAX);
        o_flags.mnib15      = (r_mnib == NIBBLE_MAX);
        o_flags.ext_gt240   = (b > LIT_EXT_MAX);
        o_flags.ext_nomatch = (b == NO_MATCH);
        o_flags.ext_end     = (b == END_MARK);
        o_flags.ext_gt236   = (b > MEXT_MAX);
        o_flags.tok_lit_ovf = ({1'b0, r_pos} + {{(POS_W - 3){1'b0}}, b[7:4]})
                              > (POS_W + 1)'(WINDOW_BYTES);
        o_flags.ext_lit_ovf = ({1'b0, r_pos} + (POS_W + 1)'(b)
                              + (POS_W + 1)'(NIBBLE_MAX)) > (POS_W + 1)'(WINDOW_BYTES);
        o_flags.lit_one     = (r_lit == 8'd1);
        o_flags.m_ovf       = (({1'b0, r_pos} + (POS_W + 1)'(r_mlen))
                              > (POS_W + 1)'(WINDOW_BYTES))
                              || (({1'b0, off} + 17'(r_mlen)) > 17'(WINDOW_BYTES));
        o_flags.bad_off     = (off >= 16'(r_pos));
        o_flags.rem_one     = (r_rem == 8'd1);
        o_flags.beat_full   = (r_bcnt == 2'd3);
    end

    assign emit_beat = i_cmd.wr_copy && (o_flags.beat_full || o_flags.rem_one);

    // output position after this cycle
    always_comb begin
        if (i_cmd.clr_pos) begin
            n_pos = '0;
        end else if (i_cmd.lit_wr || i_cmd.wr_copy) begin
            n_pos = r_pos + POS_W'(1);
        end else if (i_cmd.trunc_add) begin
            n_pos = r_pos + POS_W'(r_mlen);
        end else begin
            n_pos = r_pos;
        end
    end

    // window store
    lzd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_BYTES)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (i_cmd.lit_wr || i_cmd.wr_copy),
        .i_waddr (r_pos[WIN_AW-1:0]),
        .i_wdata (i_cmd.lit_wr ? b : q),
        .i_re    (i_cmd.rd),
        .i_raddr (r_src),
        .o_rdata (q)
    );

    // result assembly
    always_comb begin
        logic [7:0] bytes [4];
        for (int j = 0; j < 4; j++) begin
            if (j < 3 && 2'(j) < r_bcnt) begin
                bytes[j] = r_beat[(j < 3) ? j : 0];
            end else if (3'(j) == {1'b0, r_bcnt}) begin
                bytes[j] = q;
            end else begin
                bytes[j] = 8'd0;
            end
        end
        n_out              = '0;
        n_out.total_length = 14'(n_pos);
        n_out.run_last     = 1'b1;
        case (i_cmd.out_kind)
            OK_LIT: begin
                n_out.out_byte0  = b;
                n_out.byte_count = 3'd1;
                n_out.status     = ST_DATA;
            end
            OK_BEAT: begin
                n_out.out_byte0  = bytes[0];
                n_out.out_byte1  = bytes[1];
                n_out.out_byte2  = bytes[2];
                n_out.out_byte3  = bytes[3];
                n_out.byte_count = {1'b0, r_bcnt} + 3'd1;
                n_out.run_last   = o_flags.rem_one;
                n_out.status     = ST_DATA;
            end
            default: begin
                n_out.status = i_cmd.out_status;
            end
        endcase
    end

    // parse state and copy counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit   <= '0;
            r_mnib  <= '0;
            r_mlen  <= '0;
            r_offlo <= '0;
            r_pos   <= '0;
            r_bcnt  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (i_cmd.ld_mnib) begin
                r_mnib <= b[3:0];
            end
            case (i_cmd.lit_sel)
                LS_TOKEN: r_lit <= {4'd0, b[7:4]};
                LS_EXT:   r_lit <= b + 8'(NIBBLE_MAX);
                default: begin
                    if (i_cmd.dec_lit) begin
                        r_lit <= r_lit - 8'd1;
                    end
                end
            endcase
            case (i_cmd.mlen_sel)
                MS_NIB_IN: r_mlen <= {4'd0, b[3:0]} + MIN_MATCH;
                MS_NIB_RG: r_mlen <= {4'd0, r_mnib} + MIN_MATCH;
                MS_EXT:    r_mlen <= b + 8'(NIBBLE_MAX) + MIN_MATCH;
                default:   r_mlen <= r_mlen;
            endcase
            if (i_cmd.ld_offlo) begin
                r_offlo <= b;
            end
            if (i_cmd.wr_copy) begin
                r_bcnt <= emit_beat ? 2'd0 : r_bcnt + 2'd1;
            end
            if (i_cmd.out_ld) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // copy pointers, beat bytes and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_copy) begin
            r_src <= off[WIN_AW-1:0];
            r_rem <= r_mlen;
        end else if (i_cmd.wr_copy) begin
            r_src <= r_src + WIN_AW'(1);
            r_rem <= r_rem - 8'd1;
        end
        if (i_cmd.wr_copy && !emit_beat) begin
            r_beat[r_bcnt] <= q;
        end
        if (i_cmd.out_ld) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

endmodule
`default_nettype wire
